[sv/ept_pkg.sv]
// Shared constants and types for the encoder PLL position and velocity tracker.
// No dependencies; imported by encoder_pll_tracker.
package ept_pkg;

    localparam int CPR_W    = 18;
    localparam int POS_W    = 48;
    localparam int VEL_W    = 40;
    localparam int INTERP_W = 17;
    localparam int DELTA_W  = 20;
    localparam int ACC_W    = 112;

    localparam logic [31:0] SAMPLE_PERIOD_RST = 32'd214748;
    localparam logic [23:0] PROP_GAIN_RST     = 24'd256000;
    localparam logic [31:0] INT_GAIN_RST      = 32'd64000000;
    localparam logic [6:0]  POLE_PAIRS_RST    = 7'd7;

    typedef logic [1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_SAMPLE_PERIOD = 2'd0;
    localparam t_cfg_idx CFG_PROP_GAIN     = 2'd1;
    localparam t_cfg_idx CFG_INT_GAIN      = 2'd2;
    localparam t_cfg_idx CFG_POLE_PAIRS    = 2'd3;

    localparam logic signed [DELTA_W-1:0] HALF_REV = 20'sd131072;
    localparam logic signed [DELTA_W-1:0] FULL_REV = 20'sd262144;

    localparam logic [31:0]          TWO_PI_Q29 = 32'd3373259426;
    localparam logic [INTERP_W-1:0]  INTERP_ONE = 17'd65536;
    localparam logic [46:0]          POS_STEP_CAP = 47'h7FFF_FFFF_FFFF;
    localparam logic [40:0]          VEL_STEP_CAP = 41'h100_0000_0000;
    localparam logic signed [41:0]   VEL_MAX = 42'sd549755813887;
    localparam logic signed [41:0]   VEL_MIN = -42'sd549755813888;
    localparam logic signed [41:0]   INTERP_MAX = 42'sd65536;

    typedef logic [3:0] t_op;

    localparam t_op OP_KP   = 4'd0;
    localparam t_op OP_KI   = 4'd1;
    localparam t_op OP_PRED = 4'd2;
    localparam t_op OP_PCOR = 4'd3;
    localparam t_op OP_ICOR = 4'd4;
    localparam t_op OP_INTP = 4'd5;
    localparam t_op OP_EV1  = 4'd6;
    localparam t_op OP_EV2  = 4'd7;
    localparam t_op OP_PH   = 4'd8;

endpackage

[sv/encoder_pll_tracker.sv]
// Encoder frame checker, turn counter and PLL position and velocity tracker.
// One shared 32x32 multiplier with a 112-bit accumulator runs under a sequencer.
// Depends on ept_pkg.
//
//  Channel   Direction  Handshake                      Payload
//  frame     in         i_in_valid / o_in_ready        three frame bytes
//  result    out        o_out_valid / i_out_ready      eight result fields
//  config    in         i_cfg_we (no wait)             i_cfg_idx, i_cfg_data
//
// For a frame with good parity, the 20 multiplier partial products and the drain
// and update step after each of the nine multiply operations lie between acceptance
// and the next possible acceptance. A frame that fails parity skips the multiplies
// and goes straight from the check to the result.
// Reset is synchronous and returns the tracker state and registers to defaults.
// A new word is accepted while a result still waits; a finished result then
// holds the sequencer until the output register is free.
module encoder_pll_tracker
    import ept_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [7:0]         i_frame_byte_hi,
    input  logic [7:0]         i_frame_byte_mid,
    input  logic [7:0]         i_frame_byte_lo,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_parity_ok,
    output logic [17:0]        o_raw_angle,
    output logic signed [31:0] o_turn_count,
    output logic [17:0]        o_count_within_rev,
    output logic signed [31:0] o_position_turns,
    output logic signed [31:0] o_velocity_turns,
    output logic [15:0]        o_electrical_phase,
    output logic signed [31:0] o_electrical_velocity,
    input  logic               i_cfg_we,
    input  t_cfg_idx           i_cfg_idx,
    input  logic [31:0]        i_cfg_data
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CHECK = 4'd1;
    localparam logic [3:0] S_TURN  = 4'd2;
    localparam logic [3:0] S_MUL   = 4'd3;
    localparam logic [3:0] S_DRAIN = 4'd4;
    localparam logic [3:0] S_POST  = 4'd5;
    localparam logic [3:0] S_PERR  = 4'd6;
    localparam logic [3:0] S_PABS  = 4'd7;
    localparam logic [3:0] S_VABS  = 4'd8;
    localparam logic [3:0] S_DONE  = 4'd9;

    logic [31:0] r_sample_period;
    logic [23:0] r_prop_gain;
    logic [31:0] r_int_gain;
    logic [6:0]  r_pole_pairs;

    logic [3:0]                r_state, n_state;
    t_op                       r_op, n_op;
    logic [7:0]                r_byte_hi, n_byte_hi;
    logic [7:0]                r_byte_mid, n_byte_mid;
    logic [7:0]                r_byte_lo, n_byte_lo;
    logic                      r_ok, n_ok;
    logic [CPR_W-1:0]          r_raw, n_raw;
    logic signed [DELTA_W-1:0] r_delta, n_delta;
    logic [CPR_W-1:0]          r_last_raw, n_last_raw;
    logic [31:0]               r_mt, n_mt;
    logic [CPR_W-1:0]          r_in_rev, n_in_rev;
    logic [POS_W-1:0]          r_pos, n_pos;
    logic [VEL_W-1:0]          r_vel, n_vel;
    logic [INTERP_W-1:0]       r_interp, n_interp;
    logic [55:0]               r_kp, n_kp;
    logic [63:0]               r_ki, n_ki;
    logic [POS_W-1:0]          r_dp, n_dp;
    logic [63:0]               r_opa, n_opa;
    logic [63:0]               r_opb, n_opb;
    logic                      r_na2, n_na2;
    logic                      r_nb2, n_nb2;
    logic                      r_ia, n_ia;
    logic                      r_jb, n_jb;
    logic                      r_neg, n_neg;
    logic [63:0]               r_prod, n_prod;
    logic [1:0]                r_psh, n_psh;
    logic                      r_pv, n_pv;
    logic [ACC_W-1:0]          r_acc, n_acc;
    logic [31:0]               r_ev, n_ev;
    logic [15:0]               r_phase, n_phase;
    logic                      r_out_valid, n_out_valid;

    logic        r_out_ok;
    logic [17:0] r_out_raw;
    logic [31:0] r_out_turns;
    logic [17:0] r_out_in_rev;
    logic [31:0] r_out_pos;
    logic [31:0] r_out_vel;
    logic [15:0] r_out_phase;
    logic [31:0] r_out_ev;
    logic        load_out;

    logic                      par_fail;
    logic [CPR_W-1:0]          raw_asm;
    logic signed [DELTA_W-1:0] diff;
    logic signed [DELTA_W-1:0] delta;
    logic [31:0]               a_limb;
    logic [31:0]               b_limb;
    logic [63:0]               prod_now;
    logic [ACC_W-1:0]          addend;
    logic [39:0]               acc_q32;
    logic                      pc_big;
    logic [46:0]               pc_mag;
    logic                      ic_big;
    logic [40:0]               ic_mag;
    logic                      ev_big;
    logic [30:0]               ev_mag;
    logic [POS_W-1:0]          pos_pred;
    logic [POS_W-1:0]          pos_corr;
    logic signed [41:0]        vel_sum;
    logic signed [41:0]        interp_sum;
    logic [VEL_W-1:0]          vel_abs;
    logic [POS_W-1:0]          dp_abs;
    logic [POS_W-1:0]          pos_bias;
    logic [VEL_W-1:0]          vel_bias;
    logic [31:0]               ev_word;

    assign par_fail = (^{r_byte_hi, r_byte_mid}) | (^r_byte_lo[7:2]);
    assign raw_asm  = {r_byte_hi, 10'b0} | {8'b0, r_byte_mid, 2'b0} | {14'b0, r_byte_lo[7:4]};
    assign diff     = $signed({2'b00, raw_asm}) - $signed({2'b00, r_last_raw});

    always_comb begin
        if (diff > HALF_REV) begin
            delta = diff - FULL_REV;
        end else if (diff < -HALF_REV) begin
            delta = diff + FULL_REV;
        end else begin
            delta = diff;
        end
    end

    assign a_limb   = r_ia ? r_opa[63:32] : r_opa[31:0];
    assign b_limb   = r_jb ? r_opb[63:32] : r_opb[31:0];
    assign prod_now = a_limb * b_limb;

    always_comb begin
        case (r_psh)
            2'd0:    addend = {48'b0, r_prod};
            2'd1:    addend = {16'b0, r_prod, 32'b0};
            default: addend = {r_prod[47:0], 64'b0};
        endcase
    end

    assign acc_q32 = r_acc[71:32];
    assign pc_big  = |r_acc[111:87];
    assign pc_mag  = pc_big ? POS_STEP_CAP : r_acc[86:40];
    assign ic_big  = (|r_acc[111:81]) | (r_acc[80] & (|r_acc[79:40]));
    assign ic_mag  = ic_big ? VEL_STEP_CAP : r_acc[80:40];
    assign ev_big  = |r_acc[111:82];
    assign ev_mag  = r_acc[81:51];

    assign pos_pred = r_pos + ({8'b0, acc_q32} ^ {POS_W{r_neg}}) + POS_W'(r_neg);
    assign pos_corr = r_pos + ({1'b0, pc_mag} ^ {POS_W{r_neg}}) + POS_W'(r_neg);
    assign vel_sum  = $signed({{2{r_vel[VEL_W-1]}}, r_vel})
                    + $signed({1'b0, ic_mag} ^ {42{r_neg}}) + $signed(42'(r_neg));
    assign interp_sum = $signed({25'b0, r_interp})
                      + $signed({2'b0, acc_q32} ^ {42{r_neg}}) + $signed(42'(r_neg));

    assign vel_abs = r_vel[VEL_W-1] ? (~r_vel + 40'd1) : r_vel;
    assign dp_abs  = r_dp[POS_W-1] ? (~r_dp + 48'd1) : r_dp;

    assign pos_bias = r_pos + (r_pos[POS_W-1] ? 48'h3FFFF : 48'h0);
    assign vel_bias = r_vel + (r_vel[VEL_W-1] ? 40'h3FFFF : 40'h0);

    always_comb begin
        if (r_neg) begin
            ev_word = ev_big ? 32'h8000_0000 : (~{1'b0, ev_mag} + 32'd1);
        end else begin
            ev_word = ev_big ? 32'h7FFF_FFFF : {1'b0, ev_mag};
        end
    end

    assign load_out = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_byte_hi   = r_byte_hi;
        n_byte_mid  = r_byte_mid;
        n_byte_lo   = r_byte_lo;
        n_ok        = r_ok;
        n_raw       = r_raw;
        n_delta     = r_delta;
        n_last_raw  = r_last_raw;
        n_mt        = r_mt;
        n_in_rev    = r_in_rev;
        n_pos       = r_pos;
        n_vel       = r_vel;
        n_interp    = r_interp;
        n_kp        = r_kp;
        n_ki        = r_ki;
        n_dp        = r_dp;
        n_opa       = r_opa;
        n_opb       = r_opb;
        n_na2       = r_na2;
        n_nb2       = r_nb2;
        n_ia        = r_ia;
        n_jb        = r_jb;
        n_neg       = r_neg;
        n_prod      = r_prod;
        n_psh       = r_psh;
        n_pv        = 1'b0;
        n_acc       = r_pv ? (r_acc + addend) : r_acc;
        n_ev        = r_ev;
        n_phase     = r_phase;
        n_out_valid = r_out_valid && !i_out_ready;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_byte_hi  = i_frame_byte_hi;
                    n_byte_mid = i_frame_byte_mid;
                    n_byte_lo  = i_frame_byte_lo;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (par_fail) begin
                    n_ok    = 1'b0;
                    n_state = S_DONE;
                end else begin
                    n_ok    = 1'b1;
                    n_raw   = raw_asm;
                    n_delta = delta;
                    n_state = S_TURN;
                end
            end
            S_TURN: begin
                n_last_raw = r_raw;
                n_mt       = r_mt + {{(32-DELTA_W){r_delta[DELTA_W-1]}}, r_delta};
                n_in_rev   = r_in_rev + r_delta[CPR_W-1:0];
                n_op       = OP_KP;
                n_opa      = {32'b0, r_sample_period};
                n_opb      = {40'b0, r_prop_gain};
                n_na2      = 1'b0;
                n_nb2      = 1'b0;
                n_ia       = 1'b0;
                n_jb       = 1'b0;
                n_acc      = '0;
                n_state    = S_MUL;
            end
            S_MUL: begin
                n_prod = prod_now;
                n_psh  = {1'b0, r_ia} + {1'b0, r_jb};
                n_pv   = 1'b1;
                if (r_nb2 && !r_jb) begin
                    n_jb = 1'b1;
                end else begin
                    n_jb = 1'b0;
                    if (r_na2 && !r_ia) begin
                        n_ia = 1'b1;
                    end else begin
                        n_ia    = 1'b0;
                        n_state = S_DRAIN;
                    end
                end
            end
            S_DRAIN: begin
                n_state = S_POST;
            end
            S_POST: begin
                n_acc   = '0;
                n_ia    = 1'b0;
                n_jb    = 1'b0;
                n_state = S_MUL;
                case (r_op)
                    OP_KP: begin
                        n_kp  = r_acc[55:0];
                        n_op  = OP_KI;
                        n_opb = {32'b0, r_int_gain};
                    end
                    OP_KI: begin
                        n_ki  = r_acc[63:0];
                        n_op  = OP_PRED;
                        n_opa = {24'b0, vel_abs};
                        n_opb = {32'b0, r_sample_period};
                        n_neg = r_vel[VEL_W-1];
                        n_na2 = 1'b1;
                    end
                    OP_PRED: begin
                        n_pos   = pos_pred;
                        n_state = S_PERR;
                    end
                    OP_PCOR: begin
                        n_pos = pos_corr;
                        n_op  = OP_ICOR;
                        n_opb = r_ki;
                    end
                    OP_ICOR: begin
                        if (vel_sum > VEL_MAX) begin
                            n_vel = VEL_MAX[VEL_W-1:0];
                        end else if (vel_sum < VEL_MIN) begin
                            n_vel = VEL_MIN[VEL_W-1:0];
                        end else begin
                            n_vel = vel_sum[VEL_W-1:0];
                        end
                        n_state = S_VABS;
                    end
                    OP_INTP: begin
                        if (r_delta > 0) begin
                            n_interp = '0;
                        end else if (r_delta < 0) begin
                            n_interp = INTERP_ONE;
                        end else if (interp_sum[41]) begin
                            n_interp = '0;
                        end else if (interp_sum > INTERP_MAX) begin
                            n_interp = INTERP_ONE;
                        end else begin
                            n_interp = interp_sum[INTERP_W-1:0];
                        end
                        n_op  = OP_EV1;
                        n_opb = {57'b0, r_pole_pairs};
                    end
                    OP_EV1: begin
                        n_op  = OP_EV2;
                        n_opa = r_acc[63:0];
                        n_opb = {32'b0, TWO_PI_Q29};
                    end
                    OP_EV2: begin
                        n_ev  = ev_word;
                        n_op  = OP_PH;
                        n_opa = {30'b0, r_in_rev, 16'b0} + {47'b0, r_interp};
                        n_opb = {57'b0, r_pole_pairs};
                    end
                    OP_PH: begin
                        n_phase = r_acc[33:18];
                        n_state = S_DONE;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_PERR: begin
                n_dp    = {r_mt, 16'b0} - r_pos;
                n_state = S_PABS;
            end
            S_PABS: begin
                n_op    = OP_PCOR;
                n_opa   = {16'b0, dp_abs};
                n_opb   = {8'b0, r_kp};
                n_neg   = r_dp[POS_W-1];
                n_na2   = 1'b1;
                n_nb2   = 1'b1;
                n_ia    = 1'b0;
                n_jb    = 1'b0;
                n_acc   = '0;
                n_state = S_MUL;
            end
            S_VABS: begin
                n_op    = OP_INTP;
                n_opa   = {24'b0, vel_abs};
                n_opb   = {32'b0, r_sample_period};
                n_neg   = r_vel[VEL_W-1];
                n_na2   = 1'b1;
                n_nb2   = 1'b0;
                n_ia    = 1'b0;
                n_jb    = 1'b0;
                n_acc   = '0;
                n_state = S_MUL;
            end
            S_DONE: begin
                if (load_out) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pv        <= 1'b0;
            r_out_valid <= 1'b0;
            r_last_raw  <= '0;
            r_mt        <= '0;
            r_in_rev    <= '0;
            r_pos       <= '0;
            r_vel       <= '0;
            r_interp    <= '0;
        end else begin
            r_state     <= n_state;
            r_pv        <= n_pv;
            r_out_valid <= n_out_valid;
            r_last_raw  <= n_last_raw;
            r_mt        <= n_mt;
            r_in_rev    <= n_in_rev;
            r_pos       <= n_pos;
            r_vel       <= n_vel;
            r_interp    <= n_interp;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_byte_hi  <= n_byte_hi;
        r_byte_mid <= n_byte_mid;
        r_byte_lo  <= n_byte_lo;
        r_ok       <= n_ok;
        r_raw      <= n_raw;
        r_delta    <= n_delta;
        r_kp       <= n_kp;
        r_ki       <= n_ki;
        r_dp       <= n_dp;
        r_opa      <= n_opa;
        r_opb      <= n_opb;
        r_na2      <= n_na2;
        r_nb2      <= n_nb2;
        r_ia       <= n_ia;
        r_jb       <= n_jb;
        r_neg      <= n_neg;
        r_prod     <= n_prod;
        r_psh      <= n_psh;
        r_acc      <= n_acc;
        r_ev       <= n_ev;
        r_phase    <= n_phase;
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_ok <= r_ok;
            if (r_ok) begin
                r_out_raw    <= r_raw;
                r_out_turns  <= r_mt;
                r_out_in_rev <= r_in_rev;
                r_out_pos    <= {{2{pos_bias[POS_W-1]}}, pos_bias[POS_W-1:18]};
                r_out_vel    <= {{10{vel_bias[VEL_W-1]}}, vel_bias[VEL_W-1:18]};
                r_out_phase  <= r_phase;
                r_out_ev     <= r_ev;
            end else begin
                r_out_raw    <= '0;
                r_out_turns  <= '0;
                r_out_in_rev <= '0;
                r_out_pos    <= '0;
                r_out_vel    <= '0;
                r_out_phase  <= '0;
                r_out_ev     <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_period <= SAMPLE_PERIOD_RST;
            r_prop_gain     <= PROP_GAIN_RST;
            r_int_gain      <= INT_GAIN_RST;
            r_pole_pairs    <= POLE_PAIRS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SAMPLE_PERIOD: r_sample_period <= i_cfg_data;
                CFG_PROP_GAIN:     r_prop_gain     <= i_cfg_data[23:0];
                CFG_INT_GAIN:      r_int_gain      <= i_cfg_data;
                CFG_POLE_PAIRS:    r_pole_pairs    <= i_cfg_data[6:0];
                default: begin
                    r_sample_period <= r_sample_period;
                end
            endcase
        end
    end

    assign o_in_ready            = (r_state == S_IDLE);
    assign o_out_valid           = r_out_valid;
    assign o_parity_ok           = r_out_ok;
    assign o_raw_angle           = r_out_raw;
    assign o_turn_count          = $signed(r_out_turns);
    assign o_count_within_rev    = r_out_in_rev;
    assign o_position_turns      = $signed(r_out_pos);
    assign o_velocity_turns      = $signed(r_out_vel);
    assign o_electrical_phase    = r_out_phase;
    assign o_electrical_velocity = $signed(r_out_ev);

    a_accept_starts_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_CHECK))
        else $error("Accepted word did not start the parity check.");

    a_product_from_issue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pv |-> ($past(r_state) == S_MUL))
        else $error("Partial product pending without an issue cycle.");

    a_drain_has_product: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN) |-> r_pv)
        else $error("Drain cycle without a final partial product.");

    a_result_handoff: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DONE) && (!o_out_valid || i_out_ready))
            |=> (o_out_valid && (r_state == S_IDLE)))
        else $error("Finished result was not handed to the output register.");

    a_fail_word_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_parity_ok)
            |-> ((o_raw_angle == '0) && (o_turn_count == '0) && (o_velocity_turns == '0)))
        else $error("Parity failure word carries nonzero fields.");

    a_interp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |-> (r_interp <= INTERP_ONE))
        else $error("Interpolation fraction above one.");

endmodule
